/* src/gwse_pkg.sv */
// Shared types and constants for the gyro window speed estimator.
`default_nettype none

package gwse_pkg;

    localparam int RATE_W       = 16;
    localparam int ABS_W        = 17;
    localparam int SAMPLE_CNT_W = 11;
    localparam int GAIN_W       = 24;
    localparam int DURATION_W   = 8;
    localparam int SPEED_W      = 16;
    localparam int DIST_W       = 24;
    localparam int SUM_W        = 26;
    localparam int SEEN_W       = 10;
    localparam int SQ_W         = 32;
    localparam int PROD_W       = SUM_W + GAIN_W;
    localparam int GAIN_FRAC_W  = 16;
    localparam int DIVIDEND_W   = PROD_W - GAIN_FRAC_W;
    localparam int REM_W        = 18;
    localparam int CMP_W        = REM_W + 2;
    localparam int STEP_CNT_W   = 6;
    localparam int MAX_SAMPLES  = 1024;

    localparam int ROOT_STEPS   = SQ_W / 2;
    localparam int DIV_N_STEPS  = DIVIDEND_W;

    // divide by 1000 as a reciprocal multiply: ceil(2^34 / 1000), exact for
    // any dividend below 2^24
    localparam int                 DIST_SHIFT = 34;
    localparam logic [SUM_W-1:0]   DIST_RECIP = 26'd17179870;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION     = 2'd2;

    localparam logic [SAMPLE_CNT_W-1:0] SAMPLE_COUNT_RST = 11'd64;
    localparam logic [GAIN_W-1:0]       SPEED_GAIN_RST   = 24'd10007;
    localparam logic [DURATION_W-1:0]   DURATION_RST     = 8'd10;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } in_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_mm_per_s;
        logic [DIST_W-1:0]  distance_m;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_ROOT,
        ST_ACCUM,
        ST_MUL_GAIN,
        ST_DIV_LOAD,
        ST_DIV_N,
        ST_SAT,
        ST_MUL_DUR,
        ST_MUL_RECIP,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_GAIN,
        MUL_DUR,
        MUL_RECIP
    } mul_sel_t;

    typedef struct packed {
        logic     busy;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     step_en;
        logic     step_root;
    } ctl_t;

    function automatic logic [ABS_W-1:0] abs_rate(input logic signed [RATE_W-1:0] v);
        logic [ABS_W-1:0] ext;
        ext = {v[RATE_W-1], v};
        abs_rate = v[RATE_W-1] ? (~ext + ABS_W'(1)) : ext;
    endfunction

endpackage

`default_nettype wire

/* src/gyro_window_speed_estimator.sv */
// Top level: gyro window speed estimator on one shared multiplier and root/divide unit.
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  -------------------------------------
//  in        in   in_valid / in_stall    in_data  : rate_x, rate_y, rate_z
//  out       out  out_valid / out_stall  out_data : speed_mm_per_s, distance_m
//  cfg       in   cfg_write              cfg_index, cfg_data (no read-back)
//
// A sample that does not close the window goes through an idle state, the three squares in
// the multiplier and their sum, 16 root steps and an accumulate state before the next accept.
// A window-closing sample adds a gain multiply, divide load, a 34-step divide by the window
// length, saturate, duration multiply, a reciprocal multiply for the divide by 1000 and the
// output load.
// in_stall is high whenever the sequencer is not idle; a stalled output transaction
// holds the sequencer in its output state. Reset clears control state, the window
// sum, the sample counter and the config registers.
`default_nettype none

module gyro_window_speed_estimator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire gwse_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output gwse_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_write,
    input  wire logic [gwse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gwse_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gwse_pkg::*;

    // sequencer
    state_t state_reg, state_next;
    ctl_t   ctl;

    // configuration
    logic [SAMPLE_CNT_W-1:0] sample_count_reg;
    logic [GAIN_W-1:0]       speed_gain_reg;
    logic [DURATION_W-1:0]   duration_reg;

    // window state
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;

    // datapath
    in_item_t              in_reg;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SQ_W-1:0]       sq_acc_reg, sq_acc_next;
    logic [DIVIDEND_W-1:0] src_reg, src_next;
    logic [DIVIDEND_W-1:0] res_reg, res_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SAMPLE_CNT_W-1:0] divisor_reg, divisor_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic                    in_accept;
    logic                    out_free;
    logic [SAMPLE_CNT_W-1:0] win_len;
    logic [SAMPLE_CNT_W-1:0] seen_inc;
    logic                    window_done;
    logic                    step_last;
    logic [SQ_W-1:0]         sq_total;

    logic [SUM_W-1:0]  mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    logic [CMP_W-1:0] rem_shift;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] diff;
    logic             fits;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // effective window length: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            win_len = SAMPLE_CNT_W'(1);
        end
        else if (sample_count_reg > SAMPLE_CNT_W'(MAX_SAMPLES))
        begin
            win_len = SAMPLE_CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            win_len = sample_count_reg;
        end
    end

    assign seen_inc    = {1'b0, seen_reg} + SAMPLE_CNT_W'(1);
    assign window_done = !(seen_inc < win_len);
    assign sq_total    = sq_acc_reg + prod_reg[SQ_W-1:0];

    // last step of the running root or divide
    always_comb
    begin
        unique case (state_reg)
            ST_ROOT:  step_last = (cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1));
            ST_DIV_N: step_last = (cnt_reg == STEP_CNT_W'(DIV_N_STEPS - 1));
            default:  step_last = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_accept) state_next = ST_SQ_X;
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQ_Z;
            ST_SQ_Z:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:    state_next = ST_ROOT;
            ST_ROOT:      if (step_last) state_next = ST_ACCUM;
            ST_ACCUM:     state_next = window_done ? ST_MUL_GAIN : ST_IDLE;
            ST_MUL_GAIN:  state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:  state_next = ST_DIV_N;
            ST_DIV_N:     if (step_last) state_next = ST_SAT;
            ST_SAT:       state_next = ST_MUL_DUR;
            ST_MUL_DUR:   state_next = ST_MUL_RECIP;
            ST_MUL_RECIP: state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl.busy      = (state_reg != ST_IDLE);
        ctl.mul_en    = 1'b0;
        ctl.mul_sel   = MUL_X;
        ctl.step_en   = 1'b0;
        ctl.step_root = 1'b0;
        unique case (state_reg)
            ST_SQ_X:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_X;
            end
            ST_SQ_Y:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_Y;
            end
            ST_SQ_Z:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_Z;
            end
            ST_MUL_GAIN:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_GAIN;
            end
            ST_MUL_DUR:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_DUR;
            end
            ST_MUL_RECIP:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_RECIP;
            end
            ST_ROOT:
            begin
                ctl.step_en   = 1'b1;
                ctl.step_root = 1'b1;
            end
            ST_DIV_N:
            begin
                ctl.step_en = 1'b1;
            end
            default:
            begin
                ctl.mul_en = 1'b0;
            end
        endcase
    end

    assign in_stall = ctl.busy;

    // shared multiplier
    always_comb
    begin
        unique case (ctl.mul_sel)
            MUL_X:
            begin
                mul_a = SUM_W'(abs_rate(in_reg.rate_x));
                mul_b = GAIN_W'(abs_rate(in_reg.rate_x));
            end
            MUL_Y:
            begin
                mul_a = SUM_W'(abs_rate(in_reg.rate_y));
                mul_b = GAIN_W'(abs_rate(in_reg.rate_y));
            end
            MUL_Z:
            begin
                mul_a = SUM_W'(abs_rate(in_reg.rate_z));
                mul_b = GAIN_W'(abs_rate(in_reg.rate_z));
            end
            MUL_GAIN:
            begin
                mul_a = sum_reg;
                mul_b = speed_gain_reg;
            end
            MUL_DUR:
            begin
                mul_a = SUM_W'(speed_reg);
                mul_b = GAIN_W'(duration_reg);
            end
            MUL_RECIP:
            begin
                // speed * duration stays below 2^24
                mul_a = DIST_RECIP;
                mul_b = GAIN_W'(prod_reg[DIST_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared shift/compare/subtract step: root takes two radicand bits, divide one
    assign rem_shift = ctl.step_root ? {rem_reg, src_reg[DIVIDEND_W-1 -: 2]}
                                     : {1'b0, rem_reg, src_reg[DIVIDEND_W-1]};
    assign trial     = ctl.step_root ? {2'b00, res_reg[SPEED_W-1:0], 2'b01}
                                     : CMP_W'(divisor_reg);
    assign fits      = (rem_shift >= trial);
    assign diff      = rem_shift - trial;

    // datapath next values
    always_comb
    begin
        prod_next      = prod_reg;
        sq_acc_next    = sq_acc_reg;
        src_next       = src_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        speed_next     = speed_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (ctl.mul_en)
        begin
            prod_next = mul_p;
        end

        if (ctl.step_en)
        begin
            src_next = ctl.step_root ? (src_reg << 2) : (src_reg << 1);
            res_next = {res_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            cnt_next = cnt_reg + STEP_CNT_W'(1);
        end

        unique case (state_reg)
            ST_SQ_Y:
            begin
                sq_acc_next = prod_reg[SQ_W-1:0];
            end
            ST_SQ_Z:
            begin
                sq_acc_next = sq_total;
            end
            ST_SQ_SUM:
            begin
                // radicand left-aligned so the root pulls the top pair first
                src_next = {sq_total, 2'b00};
                res_next = '0;
                rem_next = '0;
                cnt_next = '0;
            end
            ST_ACCUM:
            begin
                sum_next = sum_reg + SUM_W'(res_reg[SPEED_W-1:0]);
                if (!window_done)
                begin
                    seen_next = seen_inc[SEEN_W-1:0];
                end
            end
            ST_DIV_LOAD:
            begin
                // floor((p >> 16) / n) equals floor(p / n) >> 16
                src_next     = prod_reg[PROD_W-1:GAIN_FRAC_W];
                divisor_next = win_len;
                res_next     = '0;
                rem_next     = '0;
                cnt_next     = '0;
            end
            ST_SAT:
            begin
                speed_next = (res_reg[DIVIDEND_W-1:SPEED_W] != '0) ? '1
                                                                   : res_reg[SPEED_W-1:0];
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.speed_mm_per_s = speed_reg;
                    out_data_next.distance_m     = DIST_W'(prod_reg[PROD_W-1:DIST_SHIFT]);
                    sum_next                     = '0;
                    seen_next                    = '0;
                end
            end
            default:
            begin
                sum_next = sum_next;
            end
        endcase
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            seen_reg         <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            sample_count_reg <= SAMPLE_COUNT_RST;
            speed_gain_reg   <= SPEED_GAIN_RST;
            duration_reg     <= DURATION_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[SAMPLE_CNT_W-1:0];
                    CFG_SPEED_GAIN:   speed_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_DURATION:     duration_reg     <= cfg_data[DURATION_W-1:0];
                    default:          duration_reg     <= duration_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_data;
        end
        prod_reg     <= prod_next;
        sq_acc_reg   <= sq_acc_next;
        src_reg      <= src_next;
        res_reg      <= res_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        speed_reg    <= speed_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // a transaction is only taken by an idle sequencer, which then starts on squares
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_SQ_X))
        else $error("accepted input did not start the square sequence");

    // a result only appears out of the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");

    // emitting a result clears the window
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (sum_reg == '0 && seen_reg == '0))
        else $error("window not cleared after result");

    // the shared step counter never runs past the divide step count
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step_en |-> (cnt_reg < STEP_CNT_W'(DIV_N_STEPS)))
        else $error("step counter overran");
`endif

endmodule

`default_nettype wire
